### design/ccpt_pkg.sv
package ccpt_pkg;

    // field widths
    localparam int YearW  = 16;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 6;

    // stream widths, whole bytes
    localparam int InDataW  = 48;
    localparam int OutDataW = 64;
    localparam int InUsedW  = 1 + YearW + MonthW + DayW + HourW + MinW + SecW;
    localparam int OutUsedW = YearW + MonthW + DayW + 2 * HourW + 2 * MinW + 2 * SecW;

    // counting limits
    localparam int SecLimit   = 60;
    localparam int MinLimit   = 60;
    localparam int HourLimit  = 24;
    localparam int MonthLimit = 12;

    // reset values
    localparam logic [YearW-1:0]  YearRst  = 16'd2000;
    localparam logic [MonthW-1:0] MonthRst = 4'd1;
    localparam logic [DayW-1:0]   DayRst   = 5'd1;

    // divisibility by 25 on a 16-bit year: y * inv(25) mod 2^16 <= (2^16 - 1) / 25
    localparam logic [YearW-1:0] Inv25    = 16'd23593;
    localparam logic [YearW-1:0] Div25Lim = YearW'(((1 << YearW) - 1) / 25);

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_SET  = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind           kind;
        logic                presence;
        logic [YearW-1:0]    year;
        logic [MonthW-1:0]   month;
        logic [DayW-1:0]     day;
        logic [HourW-1:0]    hour;
        logic [MinW-1:0]     minute;
        logic [SecW-1:0]     second;
    } t_req;

    typedef struct packed {
        logic [YearW-1:0]    year;
        logic [MonthW-1:0]   month;
        logic [DayW-1:0]     day;
        logic [HourW-1:0]    hour;
        logic [MinW-1:0]     minute;
        logic [SecW-1:0]     second;
        logic [HourW-1:0]    study_h;
        logic [MinW-1:0]     study_m;
        logic [SecW-1:0]     study_s;
    } t_cal;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### design/calendar_clock_with_presence_timer_core.sv
// Calendar clock with a presence-gated study timer. Each input transaction is either a
// one-second tick (tuser = 0) or a request to set the calendar time (tuser = 1); every
// input transaction yields exactly one output transaction carrying the full calendar,
// the study timer and an error flag in tuser that marks a set request with an
// out-of-range field (the clock is then left unchanged). Ticks follow Gregorian month
// lengths and leap years, the year wraps to 0 after 65535, and the study timer is
// cleared at each midnight rollover, counts only ticks with presence set and holds at
// 23:59:59. After reset the clock reads 2000-01-01 00:00:00. Throughput is one
// transaction per clock when the output side is ready: a transaction is held in the
// input register and then leaves through the output register; the combinational
// tick/set logic between the two registers (carry chain plus one 16x16 multiply for
// the leap-year test) sets the clock period.
module calendar_clock_with_presence_timer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: presence, set_year, set_month, set_day, set_hour, set_minute,
    // set_second, zero pad
    input  logic [ccpt_pkg::InDataW-1:0]  i_s_tdata,
    // tuser: req_type
    input  logic                          i_s_tuser,
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: out_year, out_month, out_day, out_hour, out_minute, out_second,
    // out_study_hours, out_study_minutes, out_study_seconds, zero pad
    output logic [ccpt_pkg::OutDataW-1:0] o_m_tdata,
    // tuser: set_error
    output logic                          o_m_tuser
);
    import ccpt_pkg::*;

    // input register
    logic   r_in_valid;
    t_req   r_in;
    t_req   w_req;

    // calendar and study timer state
    t_cal   r_cal;
    t_cal   w_nxt;
    logic   w_err;

    // output register
    logic   r_out_valid;
    logic   n_out_valid;
    t_cal   r_out;
    logic   r_out_err;

    logic   w_in_take;
    logic   w_adv;

    // unpack the input transaction, first field in the lowest bits
    always_comb begin
        w_req.kind     = t_req_kind'(i_s_tuser);
        w_req.presence = i_s_tdata[0];
        {w_req.second, w_req.minute, w_req.hour, w_req.day, w_req.month, w_req.year} =
            i_s_tdata[InUsedW-1:1];
    end

    // the held transaction moves on whenever the output register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= w_req;
        end
    end

    // tick / set logic
    ccpt_step u_step (
        .i_req (r_in),
        .i_cur (r_cal),
        .o_nxt (w_nxt),
        .o_err (w_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.year    <= YearRst;
            r_cal.month   <= MonthRst;
            r_cal.day     <= DayRst;
            r_cal.hour    <= '0;
            r_cal.minute  <= '0;
            r_cal.second  <= '0;
            r_cal.study_h <= '0;
            r_cal.study_m <= '0;
            r_cal.study_s <= '0;
        end else if (w_adv) begin
            r_cal <= w_nxt;
        end
    end

    // output register, loaded together with the state
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out     <= w_nxt;
            r_out_err <= w_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_err;
    assign o_m_tdata  = {(OutDataW-OutUsedW)'(0),
                         r_out.study_s, r_out.study_m, r_out.study_h,
                         r_out.second, r_out.minute, r_out.hour,
                         r_out.day, r_out.month, r_out.year};

endmodule

### design/ccpt_leap.sv
module ccpt_leap (
    input  logic [ccpt_pkg::YearW-1:0] i_year,
    output logic                       o_leap
);
    import ccpt_pkg::*;

    logic [YearW-1:0] w_prod;
    logic             w_div4;
    logic             w_div16;
    logic             w_div25;

    // exact divisibility test by 25 by multiplying with the modular inverse; by 4 and 16 from the low bits
    assign w_prod  = YearW'(i_year * Inv25);
    assign w_div25 = (w_prod <= Div25Lim);
    assign w_div4  = (i_year[1:0] == 2'd0);
    assign w_div16 = (i_year[3:0] == 4'd0);

    // div by 4 and not by 100, or div by 400
    assign o_leap = w_div4 && (!w_div25 || w_div16);

endmodule

### design/ccpt_step.sv
module ccpt_step (
    input  ccpt_pkg::t_req i_req,
    input  ccpt_pkg::t_cal i_cur,
    output ccpt_pkg::t_cal o_nxt,
    output logic           o_err
);
    import ccpt_pkg::*;

    logic [YearW-1:0]  w_leap_year;
    logic              w_leap;

    logic [SecW:0]     w_sec_inc;
    logic [MinW:0]     w_min_inc;
    logic [HourW:0]    w_hour_inc;
    logic [DayW:0]     w_day_inc;
    logic [MonthW:0]   w_mon_inc;
    logic              w_wrap_s;
    logic              w_wrap_m;
    logic              w_wrap_h;
    logic              w_wrap_d;
    logic              w_wrap_mo;

    logic [HourW-1:0]  w_sh;
    logic [MinW-1:0]   w_sm;
    logic [SecW-1:0]   w_ss;
    logic [SecW:0]     w_ss_inc;
    logic [MinW:0]     w_sm_inc;
    logic              w_st_wrap_s;
    logic              w_st_wrap_m;
    logic              w_st_full;

    logic              w_set_ok;
    t_cal              w_tick;

    // one leap unit: set checks the requested year, tick the current one
    assign w_leap_year = (i_req.kind == REQ_SET) ? i_req.year : i_cur.year;

    ccpt_leap u_leap (
        .i_year (w_leap_year),
        .o_leap (w_leap)
    );

    // calendar carry chain
    assign w_sec_inc  = {1'b0, i_cur.second} + (SecW+1)'(1);
    assign w_wrap_s   = (w_sec_inc >= (SecW+1)'(SecLimit));
    assign w_min_inc  = {1'b0, i_cur.minute} + (MinW+1)'(w_wrap_s);
    assign w_wrap_m   = (w_min_inc >= (MinW+1)'(MinLimit));
    assign w_hour_inc = {1'b0, i_cur.hour} + (HourW+1)'(w_wrap_m);
    assign w_wrap_h   = (w_hour_inc >= (HourW+1)'(HourLimit));
    assign w_day_inc  = {1'b0, i_cur.day} + (DayW+1)'(w_wrap_h);
    assign w_wrap_d   = (w_day_inc > {1'b0, month_len(i_cur.month, w_leap)});
    assign w_mon_inc  = {1'b0, i_cur.month} + (MonthW+1)'(w_wrap_d);
    assign w_wrap_mo  = (w_mon_inc > (MonthW+1)'(MonthLimit)) ||
                        (w_mon_inc == '0);

    // study timer, cleared at midnight before counting
    assign w_sh = w_wrap_h ? '0 : i_cur.study_h;
    assign w_sm = w_wrap_h ? '0 : i_cur.study_m;
    assign w_ss = w_wrap_h ? '0 : i_cur.study_s;

    assign w_st_full   = (w_sh >= HourW'(HourLimit - 1)) &&
                         (w_sm >= MinW'(MinLimit - 1)) &&
                         (w_ss >= SecW'(SecLimit - 1));
    assign w_ss_inc    = {1'b0, w_ss} + (SecW+1)'(1);
    assign w_st_wrap_s = (w_ss_inc >= (SecW+1)'(SecLimit));
    assign w_sm_inc    = {1'b0, w_sm} + (MinW+1)'(w_st_wrap_s);
    assign w_st_wrap_m = (w_sm_inc >= (MinW+1)'(MinLimit));

    always_comb begin
        w_tick.second = w_wrap_s ? '0 : w_sec_inc[SecW-1:0];
        w_tick.minute = w_wrap_m ? '0 : w_min_inc[MinW-1:0];
        w_tick.hour   = w_wrap_h ? '0 : w_hour_inc[HourW-1:0];
        w_tick.day    = w_wrap_d ? DayRst : w_day_inc[DayW-1:0];
        w_tick.month  = w_wrap_mo ? MonthRst : w_mon_inc[MonthW-1:0];
        w_tick.year   = i_cur.year + YearW'(w_wrap_mo);
        if (i_req.presence && !w_st_full) begin
            w_tick.study_s = w_st_wrap_s ? '0 : w_ss_inc[SecW-1:0];
            w_tick.study_m = w_st_wrap_m ? '0 : w_sm_inc[MinW-1:0];
            w_tick.study_h = w_sh + HourW'(w_st_wrap_m);
        end else begin
            w_tick.study_s = w_ss;
            w_tick.study_m = w_sm;
            w_tick.study_h = w_sh;
        end
    end

    // range check of a set request
    assign w_set_ok = (i_req.month >= MonthW'(1)) &&
                      (i_req.month <= MonthW'(MonthLimit)) &&
                      (i_req.day >= DayW'(1)) &&
                      (i_req.day <= month_len(i_req.month, w_leap)) &&
                      (i_req.hour < HourW'(HourLimit)) &&
                      (i_req.minute < MinW'(MinLimit)) &&
                      (i_req.second < SecW'(SecLimit));

    always_comb begin
        o_nxt = i_cur;
        o_err = 1'b0;
        case (i_req.kind)
            REQ_TICK: begin
                o_nxt = w_tick;
            end
            REQ_SET: begin
                if (w_set_ok) begin
                    o_nxt.year   = i_req.year;
                    o_nxt.month  = i_req.month;
                    o_nxt.day    = i_req.day;
                    o_nxt.hour   = i_req.hour;
                    o_nxt.minute = i_req.minute;
                    o_nxt.second = i_req.second;
                end else begin
                    o_err = 1'b1;
                end
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

### design/ccpt_checker.sv
module ccpt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [ccpt_pkg::OutDataW-1:0] o_m_tdata,
    input  logic                          o_m_tuser
);
    import ccpt_pkg::*;

    // a stalled result holds its data and flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser))
        else $error("result changed while stalled");

    // no result shows right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // calendar month, hour, minute and second always in range, day at least 1
    a_cal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[19:16] >= 4'd1) && (o_m_tdata[19:16] <= 4'd12) &&
        (o_m_tdata[24:20] >= 5'd1) && (o_m_tdata[29:25] <= 5'd23) &&
        (o_m_tdata[35:30] <= 6'd59) && (o_m_tdata[41:36] <= 6'd59))
        else $error("calendar field out of range");

    // study timer fields always in range, zero pad bits zero
    a_study_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[46:42] <= 5'd23) && (o_m_tdata[52:47] <= 6'd59) &&
        (o_m_tdata[58:53] <= 6'd59) && (o_m_tdata[OutDataW-1:OutUsedW] == '0))
        else $error("study timer field out of range");

endmodule

bind calendar_clock_with_presence_timer_core ccpt_checker u_ccpt_checker (.*);
